// File: rtl/core/gcm_pkg.sv
package gcm_pkg;

    // shared signed multiplier: 20-bit limbs plus a sign bit, and coordinates up to 16 bits
    localparam int MUL_W   = 21;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int LIMB_W  = 20;

    // accumulators and the final products
    localparam int ACC_W   = 40;
    localparam int VAL_W   = ACC_W - 1;      // magnitude of a positive sum
    localparam int SQ_W    = 2 * VAL_W;      // uv^2 and uu*vv
    localparam int REM_W   = SQ_W + 1;

    // quotient floor(uv^2 * 2^30 / (uu*vv)), square root operand
    localparam int Q_W     = 31;
    localparam int OP_W    = Q_W - 1;

    localparam int SCORE_W = 16;
    localparam logic [SCORE_W-1:0] SCORE_ONE = 16'h8000;
    localparam logic [SCORE_W-1:0] SCORE_ZERO = 16'h0000;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MAC  = 6'b000010,
        S_FIN  = 6'b000100,
        S_PROD = 6'b001000,
        S_ROOT = 6'b010000,
        S_DONE = 6'b100000
    } top_state_t;

    typedef enum logic [3:0] {
        R_IDLE  = 4'b0001,
        R_CHECK = 4'b0010,
        R_DIV   = 4'b0100,
        R_SQRT  = 4'b1000
    } root_state_t;

endpackage

// File: rtl/core/gcm_mul.sv
module gcm_mul (
    input  logic                                 aclk,
    input  logic signed [gcm_pkg::MUL_W-1:0]     a_i,
    input  logic signed [gcm_pkg::MUL_W-1:0]     b_i,
    output logic signed [gcm_pkg::PROD_W-1:0]    p_o
);
    import gcm_pkg::*;

    logic signed [PROD_W-1:0] p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= a_i * b_i;
    end

    assign p_o = p_reg;

endmodule

// File: rtl/core/gcm_root.sv
module gcm_root (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start_i,
    input  logic [gcm_pkg::SQ_W-1:0]          num_i,
    input  logic [gcm_pkg::SQ_W-1:0]          den_i,
    output logic                              done_o,
    output logic [gcm_pkg::SCORE_W-1:0]       score_o
);
    import gcm_pkg::*;

    root_state_t        state_reg, state_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [SQ_W-1:0]    den_reg, den_next;
    logic [OP_W-1:0]    q_reg, q_next;
    logic [OP_W-1:0]    op_reg, op_next;
    logic [OP_W-1:0]    res_reg, res_next;
    logic [OP_W-1:0]    one_reg, one_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic               done_reg, done_next;
    logic [SCORE_W-1:0] score_reg, score_next;

    logic               ge;
    logic [REM_W-1:0]   rem_sub;
    logic [Q_W-1:0]     q_full;
    logic [OP_W-1:0]    trial;
    logic               take;
    logic [OP_W-1:0]    res_step;

    always_comb begin
        ge       = rem_reg >= {1'b0, den_reg};
        rem_sub  = ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;
        q_full   = {q_reg, ge};
        trial    = res_reg + one_reg;
        take     = op_reg >= trial;
        res_step = take ? ((res_reg >> 1) + one_reg) : (res_reg >> 1);
    end

    always_comb begin
        state_next = state_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        q_next     = q_reg;
        op_next    = op_reg;
        res_next   = res_reg;
        one_next   = one_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        score_next = score_reg;
        case (state_reg)
            R_IDLE: begin
                if (start_i) begin
                    rem_next   = {1'b0, num_i};
                    den_next   = den_i;
                    state_next = R_CHECK;
                end
            end
            R_CHECK: begin
                // quotient at or above 2^31 means the score clamps to one
                if (rem_reg >= {den_reg, 1'b0}) begin
                    score_next = SCORE_ONE;
                    done_next  = 1'b1;
                    state_next = R_IDLE;
                end else begin
                    q_next     = '0;
                    cnt_next   = 5'(Q_W - 1);
                    state_next = R_DIV;
                end
            end
            R_DIV: begin
                rem_next = {rem_sub[SQ_W-1:0], 1'b0};
                q_next   = q_full[OP_W-1:0];
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0) begin
                    if (q_full[Q_W-1]) begin
                        score_next = SCORE_ONE;
                        done_next  = 1'b1;
                        state_next = R_IDLE;
                    end else begin
                        op_next    = q_full[OP_W-1:0];
                        res_next   = '0;
                        one_next   = OP_W'(1) << (OP_W - 2);
                        cnt_next   = 5'(OP_W / 2 - 1);
                        state_next = R_SQRT;
                    end
                end
            end
            R_SQRT: begin
                if (take) begin
                    op_next = op_reg - trial;
                end
                res_next = res_step;
                one_next = one_reg >> 2;
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0) begin
                    score_next = {1'b0, res_step[SCORE_W-2:0]};
                    done_next  = 1'b1;
                    state_next = R_IDLE;
                end
            end
            default: begin
                state_next = R_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= R_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        rem_reg   <= rem_next;
        den_reg   <= den_next;
        q_reg     <= q_next;
        op_reg    <= op_next;
        res_reg   <= res_next;
        one_reg   <= one_next;
        cnt_reg   <= cnt_next;
        score_reg <= score_next;
    end

    assign done_o  = done_reg;
    assign score_o = score_reg;

endmodule

// File: rtl/core/gesture_cosine_match_unit.sv
// Both points present: the shared multiplier forms six coordinate products one per cycle
// behind its output register while the input is held off. Padding or mismatched
// pairs: one per cycle. A scored last pair then runs eight 20-bit limb products, a 31-step
// restoring divide and a 15-step square root; a zero score skips these.
// A result still waiting on m_ready holds off the input until the output register frees.
// Reset (aresetn low, synchronous) clears the sums, the mismatch flag and any result.
module gesture_cosine_match_unit #(
    parameter int COORD_WIDTH = 10
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [COORD_WIDTH-1:0]       s_ax,
    input  logic signed [COORD_WIDTH-1:0]       s_ay,
    input  logic                                s_a_present,
    input  logic signed [COORD_WIDTH-1:0]       s_bx,
    input  logic signed [COORD_WIDTH-1:0]       s_by,
    input  logic                                s_b_present,
    input  logic                                s_last_pair,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [gcm_pkg::SCORE_W-1:0]         m_score,
    output logic                                m_shapes_differ
);
    import gcm_pkg::*;

    top_state_t               state_reg, state_next;
    logic [3:0]               step_reg, step_next;
    logic signed [MUL_W-1:0]  ax_reg, ax_next, ay_reg, ay_next;
    logic signed [MUL_W-1:0]  bx_reg, bx_next, by_reg, by_next;
    logic                     last_reg, last_next;
    logic                     mismatch_reg, mismatch_next;
    logic signed [ACC_W-1:0]  cross_reg, cross_next;
    logic signed [ACC_W-1:0]  sa_reg, sa_next;
    logic signed [ACC_W-1:0]  sb_reg, sb_next;
    logic signed [PROD_W-1:0] part_reg, part_next;
    logic [SQ_W-1:0]          sq_reg, sq_next;
    logic [SQ_W-1:0]          pq_reg, pq_next;
    logic [SCORE_W-1:0]       score_reg, score_next;
    logic                     m_valid_reg, m_valid_next;
    logic [SCORE_W-1:0]       m_score_reg, m_score_next;
    logic                     m_diff_reg, m_diff_next;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic                     root_start;
    logic                     root_done;
    logic [SCORE_W-1:0]       root_score;
    logic [3:0]               prev;
    logic [VAL_W-1:0]         lx, ly;
    logic [SQ_W-1:0]          pp_shift;

    function automatic logic signed [MUL_W-1:0] sext(input logic signed [COORD_WIDTH-1:0] v);
        return {{(MUL_W-COORD_WIDTH){v[COORD_WIDTH-1]}}, v};
    endfunction

    function automatic logic signed [MUL_W-1:0] limb(input logic [VAL_W-1:0] v,
                                                     input logic hi);
        logic [LIMB_W-1:0] l;
        l = hi ? LIMB_W'(v[VAL_W-1:LIMB_W]) : v[LIMB_W-1:0];
        return {1'b0, l};
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] acc,
                                                        input logic signed [PROD_W-1:0] x,
                                                        input logic signed [PROD_W-1:0] y);
        logic signed [ACC_W+2:0] s;
        s = (ACC_W+3)'(acc) + (ACC_W+3)'(x) + (ACC_W+3)'(y);
        if (s > (ACC_W+3)'(ACC_MAX)) begin
            return ACC_MAX;
        end else if (s < (ACC_W+3)'(ACC_MIN)) begin
            return ACC_MIN;
        end
        return s[ACC_W-1:0];
    endfunction

    gcm_mul u_mul (
        .aclk (aclk),
        .a_i  (mul_a),
        .b_i  (mul_b),
        .p_o  (mul_p)
    );

    gcm_root u_root (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start_i (root_start),
        .num_i   (sq_reg),
        .den_i   (pq_reg),
        .done_o  (root_done),
        .score_o (root_score)
    );

    assign root_start = (state_reg == S_ROOT) && (step_reg == 4'd0);
    assign prev = step_reg - 4'd1;

    // operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        lx    = step_reg[2] ? sa_reg[VAL_W-1:0] : cross_reg[VAL_W-1:0];
        ly    = step_reg[2] ? sb_reg[VAL_W-1:0] : cross_reg[VAL_W-1:0];
        case (state_reg)
            S_MAC: begin
                case (step_reg)
                    4'd0: begin mul_a = ax_reg; mul_b = bx_reg; end
                    4'd1: begin mul_a = ay_reg; mul_b = by_reg; end
                    4'd2: begin mul_a = ax_reg; mul_b = ax_reg; end
                    4'd3: begin mul_a = ay_reg; mul_b = ay_reg; end
                    4'd4: begin mul_a = bx_reg; mul_b = bx_reg; end
                    4'd5: begin mul_a = by_reg; mul_b = by_reg; end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            S_PROD: begin
                mul_a = limb(lx, step_reg[1]);
                mul_b = limb(ly, step_reg[0]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // place the previous limb product by its weight
    always_comb begin
        case (prev[1:0])
            2'd0:    pp_shift = SQ_W'(mul_p[2*LIMB_W-1:0]);
            2'd3:    pp_shift = SQ_W'(mul_p[2*LIMB_W-1:0]) << (2 * LIMB_W);
            default: pp_shift = SQ_W'(mul_p[2*LIMB_W-1:0]) << LIMB_W;
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        step_next     = step_reg;
        ax_next       = ax_reg;
        ay_next       = ay_reg;
        bx_next       = bx_reg;
        by_next       = by_reg;
        last_next     = last_reg;
        mismatch_next = mismatch_reg;
        cross_next    = cross_reg;
        sa_next       = sa_reg;
        sb_next       = sb_reg;
        part_next     = part_reg;
        sq_next       = sq_reg;
        pq_next       = pq_reg;
        score_next    = score_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_score_next  = m_score_reg;
        m_diff_next   = m_diff_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    ax_next   = sext(s_ax);
                    ay_next   = sext(s_ay);
                    bx_next   = sext(s_bx);
                    by_next   = sext(s_by);
                    last_next = s_last_pair;
                    if (s_a_present != s_b_present) begin
                        mismatch_next = 1'b1;
                    end
                    if (s_a_present && s_b_present) begin
                        step_next  = 4'd0;
                        state_next = S_MAC;
                    end else if (s_last_pair) begin
                        state_next = S_FIN;
                    end
                end
            end
            S_MAC: begin
                step_next = step_reg + 4'd1;
                case (step_reg)
                    4'd1, 4'd3, 4'd5: part_next = mul_p;
                    4'd2: cross_next = sat_add(cross_reg, part_reg, mul_p);
                    4'd4: sa_next = sat_add(sa_reg, part_reg, mul_p);
                    4'd6: begin
                        sb_next    = sat_add(sb_reg, part_reg, mul_p);
                        state_next = last_reg ? S_FIN : S_IDLE;
                    end
                    default: part_next = part_reg;
                endcase
            end
            S_FIN: begin
                if (mismatch_reg || cross_reg <= 0 || sa_reg <= 0 || sb_reg <= 0) begin
                    score_next = SCORE_ZERO;
                    state_next = S_DONE;
                end else begin
                    sq_next    = '0;
                    pq_next    = '0;
                    step_next  = 4'd0;
                    state_next = S_PROD;
                end
            end
            S_PROD: begin
                step_next = step_reg + 4'd1;
                if (step_reg != 4'd0) begin
                    if (prev[2]) begin
                        pq_next = pq_reg + pp_shift;
                    end else begin
                        sq_next = sq_reg + pp_shift;
                    end
                end
                if (step_reg == 4'd8) begin
                    step_next  = 4'd0;
                    state_next = S_ROOT;
                end
            end
            S_ROOT: begin
                step_next = 4'd1;
                if (root_done) begin
                    score_next = root_score;
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_score_next  = score_reg;
                    m_diff_next   = mismatch_reg;
                    cross_next    = '0;
                    sa_next       = '0;
                    sb_next       = '0;
                    mismatch_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            step_reg     <= 4'd0;
            mismatch_reg <= 1'b0;
            cross_reg    <= '0;
            sa_reg       <= '0;
            sb_reg       <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            mismatch_reg <= mismatch_next;
            cross_reg    <= cross_next;
            sa_reg       <= sa_next;
            sb_reg       <= sb_next;
            m_valid_reg  <= m_valid_next;
        end
        ax_reg      <= ax_next;
        ay_reg      <= ay_next;
        bx_reg      <= bx_next;
        by_reg      <= by_next;
        last_reg    <= last_next;
        part_reg    <= part_next;
        sq_reg      <= sq_next;
        pq_reg      <= pq_next;
        score_reg   <= score_next;
        m_score_reg <= m_score_next;
        m_diff_reg  <= m_diff_next;
    end

    assign s_ready         = (state_reg == S_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_score         = m_score_reg;
    assign m_shapes_differ = m_diff_reg;

endmodule

// File: tb/gesture_cosine_match_unit_test.sv
`timescale 1ns / 100ps

module gesture_cosine_match_unit_test;
    import gcm_pkg::*;

    localparam int COORD_W = 10;
    localparam int COORD_MAX = (1 << (COORD_W - 1)) - 1;
    localparam int COORD_MIN = -(1 << (COORD_W - 1));
    localparam int LIMIT_CYCLES = 400000;
    localparam int TAIL_CYCLES = 100;
    localparam int LONG_HOLD = 400;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct {
        logic [SCORE_W-1:0] score;
        logic               shapes_differ;
    } match_result_t;

    typedef enum {SINK_OPEN, SINK_PATTERN} sink_mode_t;
    typedef enum {GEST_CLEAN, GEST_BROKEN, GEST_NOISE} gesture_style_t;

    logic   aclk;
    logic   aresetn = 1'b0;
    logic   s_valid = 1'b0;
    logic   s_ready;
    coord_t s_ax = '0;
    coord_t s_ay = '0;
    logic   s_a_present = 1'b0;
    coord_t s_bx = '0;
    coord_t s_by = '0;
    logic   s_b_present = 1'b0;
    logic   s_last_pair = 1'b0;
    logic   m_valid;
    logic   m_ready = 1'b0;
    logic [SCORE_W-1:0] m_score;
    logic   m_shapes_differ;

    // predictor state
    logic signed [ACC_W-1:0] cross_acc = '0;
    logic signed [ACC_W-1:0] a_energy = '0;
    logic signed [ACC_W-1:0] b_energy = '0;
    logic                    shape_mismatch = 1'b0;
    match_result_t           pending_matches[$];

    // sender and receiver control
    bit         gaps_on = 1'b0;
    int         burst_left = 0;
    sink_mode_t sink_mode = SINK_OPEN;
    int         hold_request = 0;
    int         hold_left = 0;
    logic [15:0] stall_pattern = 16'hffff;
    int         pattern_pos = 0;

    int pairs_sent = 0;
    int scores_seen = 0;
    int full_scores = 0;
    int differ_scores = 0;
    int zero_scores = 0;
    int fail_count = 0;
    int cycle_count = 0;

    gesture_cosine_match_unit #(
        .COORD_WIDTH(COORD_W)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_ax(s_ax),
        .s_ay(s_ay),
        .s_a_present(s_a_present),
        .s_bx(s_bx),
        .s_by(s_by),
        .s_b_present(s_b_present),
        .s_last_pair(s_last_pair),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_score(m_score),
        .m_shapes_differ(m_shapes_differ)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d scores still pending",
                     cycle_count, pending_matches.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // largest s in [0, 1.0] with s^2 * uu * vv <= uv^2 * 2^30
    function automatic logic [SCORE_W-1:0] cosine_q15_score(logic [ACC_W-2:0] uv,
                                                            logic [ACC_W-2:0] uu,
                                                            logic [ACC_W-2:0] vv);
        logic [127:0] rhs;
        logic [127:0] base;
        logic [127:0] lhs;
        logic [31:0]  lo;
        logic [31:0]  hi;
        logic [31:0]  mid;
        rhs = 128'(uv) * 128'(uv);
        rhs = rhs << 30;
        base = 128'(uu) * 128'(vv);
        lo = 0;
        hi = 32'(SCORE_ONE);
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            lhs = base * 128'(mid * mid);
            if (lhs <= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo[SCORE_W-1:0];
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_sum(logic signed [ACC_W-1:0] acc,
                                                        longint term);
        longint total;
        total = longint'(acc) + term;
        if (total > longint'(ACC_MAX))
            return ACC_MAX;
        if (total < longint'(ACC_MIN))
            return ACC_MIN;
        return total[ACC_W-1:0];
    endfunction

    function automatic void accumulate_pair(coord_t ax, coord_t ay, bit ap,
                                            coord_t bx, coord_t by, bit bp, bit last_one);
        match_result_t r;
        if (ap != bp) begin
            shape_mismatch = 1'b1;
        end else if (ap) begin
            cross_acc = sat_sum(cross_acc, longint'(ax) * longint'(bx)
                                         + longint'(ay) * longint'(by));
            a_energy = sat_sum(a_energy, longint'(ax) * longint'(ax)
                                       + longint'(ay) * longint'(ay));
            b_energy = sat_sum(b_energy, longint'(bx) * longint'(bx)
                                       + longint'(by) * longint'(by));
        end
        if (last_one) begin
            r.shapes_differ = shape_mismatch;
            if (shape_mismatch || cross_acc <= 0 || a_energy <= 0 || b_energy <= 0)
                r.score = SCORE_ZERO;
            else
                r.score = cosine_q15_score(cross_acc[ACC_W-2:0], a_energy[ACC_W-2:0],
                                           b_energy[ACC_W-2:0]);
            pending_matches.push_back(r);
            cross_acc = '0;
            a_energy = '0;
            b_energy = '0;
            shape_mismatch = 1'b0;
        end
    endfunction

    function automatic void log_failure(string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("[%0t] %s", $realtime, msg);
    endfunction

    always @(posedge aclk) begin : check_scores
        match_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_matches.size() == 0) begin
                log_failure($sformatf("unexpected score transaction: score=%0d differ=%0b",
                                      m_score, m_shapes_differ));
            end else begin
                want = pending_matches.pop_front();
                scores_seen++;
                if (want.score == SCORE_ONE)
                    full_scores++;
                if (want.score == SCORE_ZERO)
                    zero_scores++;
                if (want.shapes_differ)
                    differ_scores++;
                if (m_score !== want.score || m_shapes_differ !== want.shapes_differ)
                    log_failure($sformatf("score #%0d: expected score=%0d differ=%0b, got %0d %0b",
                                          scores_seen, want.score, want.shapes_differ,
                                          m_score, m_shapes_differ));
            end
        end
    end

    // receiver: long holds first, otherwise open or a rotating stall pattern
    always @(negedge aclk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (sink_mode == SINK_OPEN) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= stall_pattern[pattern_pos];
            pattern_pos = (pattern_pos + 1) % 16;
            if (pattern_pos == 0)
                stall_pattern = 16'($urandom | $urandom);
        end
    end

    task automatic set_sink(sink_mode_t mode);
        @(posedge aclk);
        sink_mode = mode;
    endtask

    task automatic sender_idle();
        int gap;
        if (!gaps_on)
            return;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        gap = $urandom_range(1, 12);
        @(negedge aclk);
        s_valid <= 1'b0;
        repeat (gap - 1) @(negedge aclk);
        burst_left = $urandom_range(0, 9);
    endtask

    task automatic send_pair(coord_t ax, coord_t ay, bit ap,
                             coord_t bx, coord_t by, bit bp, bit last_one);
        @(negedge aclk);
        s_ax <= ax;
        s_ay <= ay;
        s_a_present <= ap;
        s_bx <= bx;
        s_by <= by;
        s_b_present <= bp;
        s_last_pair <= last_one;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        accumulate_pair(ax, ay, ap, bx, by, bp, last_one);
        if (ap || bp || last_one)
            pairs_sent++;
        sender_idle();
    endtask

    task automatic sender_stop();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        sender_stop();
        while (pending_matches.size() != 0) @(negedge aclk);
    endtask

    function automatic coord_t clip_coord(int v);
        if (v > COORD_MAX)
            v = COORD_MAX;
        if (v < COORD_MIN)
            v = COORD_MIN;
        return coord_t'(v);
    endfunction

    task automatic send_both(int ax, int ay, int bx, int by, bit last_one);
        send_pair(clip_coord(ax), clip_coord(ay), 1'b1, clip_coord(bx), clip_coord(by), 1'b1,
                  last_one);
    endtask

    function automatic int rand_coord(int shift);
        int v;
        v = $urandom_range(0, (1 << COORD_W) - 1);
        v = v + COORD_MIN;
        return v >>> shift;
    endfunction

    function automatic int jitter(int n);
        int v;
        v = $urandom_range(0, 2 * n);
        return v - n;
    endfunction

    function automatic int pick_length();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(13, 40);
        return $urandom_range(1, 12);
    endfunction

    function automatic gesture_style_t pick_style();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return GEST_NOISE;
        if (r == 1)
            return GEST_BROKEN;
        return GEST_CLEAN;
    endfunction

    // b is related to a so that scores spread over the whole range
    task automatic send_gesture(int len, gesture_style_t style);
        int relation;
        int noise;
        int shift;
        int flip_at;
        int i;
        int xa, ya, xb, yb;
        bit pa, pb;
        relation = $urandom_range(0, 3);
        noise = ($urandom_range(0, 2) == 0) ? 0 : (1 << $urandom_range(0, 6));
        shift = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
        flip_at = $urandom_range(0, len - 1);
        for (i = 0; i < len; i++) begin
            xa = rand_coord(shift);
            ya = rand_coord(shift);
            case (relation)
                0: begin
                    xb = xa + jitter(noise);
                    yb = ya + jitter(noise);
                end
                1: begin
                    xb = -xa + jitter(noise);
                    yb = -ya + jitter(noise);
                end
                2: begin
                    xb = xa >>> 1;
                    yb = ya >>> 1;
                end
                default: begin
                    xb = rand_coord(shift);
                    yb = rand_coord(shift);
                end
            endcase
            pa = 1'b1;
            pb = 1'b1;
            if ($urandom_range(0, 15) == 0) begin
                pa = 1'b0;
                pb = 1'b0;
            end
            if (style == GEST_BROKEN && i == flip_at) begin
                pa = 1'($urandom_range(0, 1));
                pb = !pa;
            end else if (style == GEST_NOISE) begin
                pa = 1'($urandom_range(0, 1));
                pb = 1'($urandom_range(0, 1));
            end
            send_pair(clip_coord(xa), clip_coord(ya), pa, clip_coord(xb), clip_coord(yb), pb,
                      i == len - 1);
        end
    endtask

    task automatic test_directed_cases();
        gaps_on = 1'b0;
        set_sink(SINK_OPEN);
        send_both(511, 511, 511, 511, 1'b1);            // identical, full score
        send_both(-512, -512, -512, -512, 1'b1);
        send_both(-512, -512, 511, 511, 1'b1);          // opposite direction
        send_both(511, 0, 0, -512, 1'b1);               // orthogonal
        send_both(0, 0, 0, 0, 1'b1);                    // both vectors zero
        send_both(0, 0, 5, -7, 1'b1);
        send_pair(clip_coord(0), clip_coord(0), 1'b0,
                  clip_coord(0), clip_coord(0), 1'b0, 1'b1);      // empty comparison
        send_both(3, 4, 6, 8, 1'b0);
        send_both(6, 8, 12, 16, 1'b1);
        send_pair(clip_coord(100), clip_coord(50), 1'b1,
                  clip_coord(0), clip_coord(0), 1'b0, 1'b0);      // stroke length differs
        send_both(100, 50, 100, 50, 1'b1);
        send_both(7, 7, 7, 7, 1'b0);
        send_pair(clip_coord(-1), clip_coord(-1), 1'b0,
                  clip_coord(9), clip_coord(9), 1'b1, 1'b1);      // mismatch on the last pair
        send_both(200, -100, 180, -90, 1'b0);
        send_pair(clip_coord(511), clip_coord(511), 1'b0,
                  clip_coord(-512), clip_coord(-512), 1'b0, 1'b0);  // padding mid-gesture
        send_both(-300, 10, -280, 40, 1'b1);
        send_both(1, 0, 1, 1, 1'b1);
        send_both(511, -512, 511, -511, 1'b1);
        sender_stop();
    endtask

    task automatic test_random_gestures(int target);
        while (pairs_sent < target) begin
            if ($urandom_range(0, 5) == 0) begin
                gaps_on = ($urandom_range(0, 2) != 0);
                set_sink(($urandom_range(0, 2) == 0) ? SINK_OPEN : SINK_PATTERN);
            end
            send_gesture(pick_length(), pick_style());
        end
        sender_stop();
    endtask

    // receiver stalls long enough that the unit backs up into its input
    task automatic test_output_backpressure();
        gaps_on = 1'b0;
        set_sink(SINK_PATTERN);
        @(posedge aclk);
        hold_request = LONG_HOLD;
        repeat (16) send_gesture($urandom_range(1, 4), GEST_CLEAN);
        sender_stop();
    endtask

    task automatic test_idle_between_gestures();
        gaps_on = 1'b1;
        repeat (4) begin
            repeat (3) send_gesture($urandom_range(1, 5), pick_style());
            wait_drained();
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_cases();
        test_random_gestures(440);
        test_output_backpressure();
        test_idle_between_gestures();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_matches.size() != 0)
            log_failure($sformatf("%0d scores never arrived", pending_matches.size()));

        $display("Sent %0d point pairs over %0d comparisons in %0d cycles.",
                 pairs_sent, scores_seen, cycle_count);
        $display("Scores: %0d at 1.0, %0d zero, %0d with shapes differing; %0d failures.",
                 full_scores, zero_scores, differ_scores, fail_count);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
